// File: hdl/kdsl_pkg.sv
// kdsl_pkg: shared types and constants for the key debounce block
// request payloads, configuration bundle, press machine states
// no dependencies
package kdsl_pkg;

  localparam int unsigned MAX_KEYS = 8;
  localparam int unsigned KEY_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd2;

  localparam logic [COUNT_W-1:0] KEY_COUNT_RST = 4'd3;
  localparam logic [LIMIT_W-1:0] DEBOUNCE_RST = 16'd60;
  localparam logic [LIMIT_W-1:0] LONG_PRESS_RST = 16'd640;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_PRESSED = 2'd2,
    MODE_IGNORE = 2'd3
  } mode_t;

  typedef struct packed {
    logic action;
    logic [KEY_W-1:0] key_bits;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic code_valid;
    logic [CODE_W-1:0] key_code;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] key_count;
    logic [LIMIT_W-1:0] debounce_ms;
    logic [LIMIT_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic [CODE_W-1:0] code;
  } push_t;

endpackage

// File: hdl/kdsl_press.sv
// kdsl_press: debounce and short/long press state machine
// depends on kdsl_pkg; emits one push request per qualified press
module kdsl_press (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_en,
  input  logic [kdsl_pkg::KEY_W-1:0]    key_bits,
  input  logic [kdsl_pkg::TIME_W-1:0]   now_ms,
  input  kdsl_pkg::cfg_t                cfg,
  output kdsl_pkg::push_t               push
);

  kdsl_pkg::mode_t mode, mode_next;
  logic [kdsl_pkg::KEY_W-1:0] held_pattern, held_pattern_next;
  logic [kdsl_pkg::TIME_W-1:0] mark_time, mark_time_next;

  logic [kdsl_pkg::COUNT_W-1:0] n_eff;
  logic [kdsl_pkg::KEY_W-1:0] mask;
  logic [kdsl_pkg::KEY_W-1:0] keys;
  logic [kdsl_pkg::TIME_W-1:0] elapsed;
  logic single;
  logic [2:0] idx;
  logic debounce_over, long_over;

  always_comb begin
    n_eff = (cfg.key_count > kdsl_pkg::COUNT_W'(kdsl_pkg::MAX_KEYS))
          ? kdsl_pkg::COUNT_W'(kdsl_pkg::MAX_KEYS) : cfg.key_count;
    for (int i = 0; i < kdsl_pkg::KEY_W; i++) begin
      mask[i] = (kdsl_pkg::COUNT_W'(i) < n_eff);
    end
    keys = key_bits & mask;
    elapsed = now_ms - mark_time;
    debounce_over = (elapsed > {16'd0, cfg.debounce_ms});
    long_over = (elapsed > {16'd0, cfg.long_press_ms});
    // exactly one key in the held pattern
    single = (held_pattern != '0) &&
             ((held_pattern & (held_pattern - kdsl_pkg::KEY_W'(1))) == '0);
    idx = '0;
    for (int i = 0; i < kdsl_pkg::KEY_W; i++) begin
      if (held_pattern[i]) idx = 3'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= kdsl_pkg::MODE_RELEASED;
      held_pattern <= '0;
      mark_time <= '0;
    end else if (sample_en) begin
      mode <= mode_next;
      held_pattern <= held_pattern_next;
      mark_time <= mark_time_next;
    end
  end

  always_comb begin
    mode_next = mode;
    held_pattern_next = held_pattern;
    mark_time_next = mark_time;
    push.valid = 1'b0;
    push.code = {1'b0, idx};
    unique case (mode)
      kdsl_pkg::MODE_RELEASED: begin
        if (keys != '0) begin
          held_pattern_next = keys;
          mark_time_next = now_ms;
          mode_next = kdsl_pkg::MODE_DEBOUNCE;
        end
      end
      kdsl_pkg::MODE_DEBOUNCE: begin
        if (debounce_over) begin
          if (keys == held_pattern) begin
            mark_time_next = now_ms;
            mode_next = kdsl_pkg::MODE_PRESSED;
          end else begin
            mode_next = kdsl_pkg::MODE_IGNORE;
          end
        end else if (keys != held_pattern) begin
          mode_next = kdsl_pkg::MODE_IGNORE;
        end
      end
      kdsl_pkg::MODE_PRESSED: begin
        if (keys != '0) begin
          if (keys != held_pattern) begin
            mode_next = kdsl_pkg::MODE_IGNORE;
          end else if (long_over) begin
            // long code is offset by the key count
            push.valid = sample_en && single;
            push.code = {1'b0, idx} + n_eff;
            mode_next = kdsl_pkg::MODE_IGNORE;
          end
        end else begin
          push.valid = sample_en && single;
          mode_next = kdsl_pkg::MODE_RELEASED;
        end
      end
      kdsl_pkg::MODE_IGNORE: begin
        if (keys == '0) mode_next = kdsl_pkg::MODE_RELEASED;
      end
      default: begin
        mode_next = kdsl_pkg::MODE_RELEASED;
      end
    endcase
  end

endmodule

// File: hdl/kdsl_queue.sv
// kdsl_queue: ring queue of key codes with registered pop result
// depends on kdsl_pkg; one slot stays free so equal pointers mean empty
module kdsl_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kdsl_pkg::push_t      push,
  input  logic                 pop_en,
  input  logic                 out_stall,
  output logic                 out_valid,
  output kdsl_pkg::out_item_t  out_item
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [kdsl_pkg::CODE_W-1:0] mem [DEPTH];
  logic [PW-1:0] write_ptr, read_ptr;
  logic [PW-1:0] write_ptr_next, read_ptr_next;
  logic full, empty;

  always_comb begin
    write_ptr_next = (write_ptr == LAST) ? '0 : write_ptr + PW'(1);
    read_ptr_next = (read_ptr == LAST) ? '0 : read_ptr + PW'(1);
    full = (write_ptr_next == read_ptr);
    empty = (write_ptr == read_ptr);
  end

  always_ff @(posedge clk) begin
    if (push.valid && !full) mem[write_ptr] <= push.code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr <= '0;
    end else begin
      if (push.valid && !full) write_ptr <= write_ptr_next;
      if (pop_en && !empty) read_ptr <= read_ptr_next;
    end
  end

  // result register; pop_en only comes when it is free or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_en) begin
      out_item.code_valid <= !empty;
      out_item.key_code <= empty ? '0 : mem[read_ptr];
    end
  end

endmodule

// File: hdl/key_debounce_short_long_fifo_top.sv
// Key debounce with short/long press detection and a code queue. Each request
// lands in an input register and is processed from there (a read request waits
// while the result register is stalled): a sample request steps the press
// machine (pushing a code when a press qualifies), a read request pops the queue
// into the result register. One request per cycle is taken while in_stall is low;
// a read result passes through the input register and then the result register.
// in_stall rises only when a read request waits in the input register while
// the result register holds a result that is itself stalled. The queue holds
// QUEUE_DEPTH-1 codes and drops new codes when full. Configuration writes are
// always ready and take effect on the next request.
// depends on kdsl_pkg, kdsl_press, kdsl_queue
module key_debounce_short_long_fifo_top #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  kdsl_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output kdsl_pkg::out_item_t                  out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kdsl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kdsl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  kdsl_pkg::cfg_t cfg;
  kdsl_pkg::in_item_t in_q;
  logic in_q_valid;
  logic sample_en, pop_en;
  kdsl_pkg::push_t push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_count <= kdsl_pkg::KEY_COUNT_RST;
      cfg.debounce_ms <= kdsl_pkg::DEBOUNCE_RST;
      cfg.long_press_ms <= kdsl_pkg::LONG_PRESS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kdsl_pkg::CFG_KEY_COUNT: cfg.key_count <= cfg_data[kdsl_pkg::COUNT_W-1:0];
        kdsl_pkg::CFG_DEBOUNCE: cfg.debounce_ms <= cfg_data;
        kdsl_pkg::CFG_LONG_PRESS: cfg.long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // a read request must wait while the result register cannot move
  assign in_stall = in_q_valid && (in_q.action == kdsl_pkg::ACT_READ)
                    && out_valid && out_stall;
  assign sample_en = in_q_valid && (in_q.action == kdsl_pkg::ACT_SAMPLE);
  assign pop_en = in_q_valid && (in_q.action == kdsl_pkg::ACT_READ) && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) in_q <= in_item;
  end

  kdsl_press u_press (
    .clk       (clk),
    .rst       (rst),
    .sample_en (sample_en),
    .key_bits  (in_q.key_bits),
    .now_ms    (in_q.now_ms),
    .cfg       (cfg),
    .push      (push)
  );

  kdsl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop_en    (pop_en),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: hdl/kdsl_checker.sv
// kdsl_checker: port-level checks for the key debounce block
// depends on kdsl_pkg; bound to key_debounce_short_long_fifo_top
module kdsl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input kdsl_pkg::in_item_t              in_item,
  input logic                            out_valid,
  input logic                            out_stall,
  input kdsl_pkg::out_item_t             out_item
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_empty_code_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.code_valid) |-> (out_item.key_code == '0))
    else $error("empty read carries a nonzero code");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_item.action, 2))
    else $error("result without a read request two cycles earlier");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind key_debounce_short_long_fifo_top kdsl_checker u_kdsl_checker (.*);

// File: verif/key_debounce_short_long_fifo_tb.sv
// self-checking testbench for key_debounce_short_long_fifo_top
// press sequences with timed samples, code reads, and register writes between phases
// depends on kdsl_pkg and the top-level rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 6;

  // tracks press machine and code queue, holds the read results still due
  class press_code_tracker;
    logic [kdsl_pkg::COUNT_W-1:0] key_count;
    logic [kdsl_pkg::LIMIT_W-1:0] debounce_ms;
    logic [kdsl_pkg::LIMIT_W-1:0] long_press_ms;
    kdsl_pkg::mode_t mode;
    logic [kdsl_pkg::KEY_W-1:0] held;
    logic [kdsl_pkg::TIME_W-1:0] mark;
    logic [kdsl_pkg::CODE_W-1:0] slots [QDEPTH];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    kdsl_pkg::out_item_t codes_due [$];
    int unsigned failures;
    int unsigned reported;

    function new();
      key_count = kdsl_pkg::KEY_COUNT_RST;
      debounce_ms = kdsl_pkg::DEBOUNCE_RST;
      long_press_ms = kdsl_pkg::LONG_PRESS_RST;
      mode = kdsl_pkg::MODE_RELEASED;
      held = '0;
      mark = '0;
      wr_ptr = 0;
      rd_ptr = 0;
      failures = 0;
      reported = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void write_reg(logic [kdsl_pkg::CFG_IDX_W-1:0] idx,
                            logic [kdsl_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        kdsl_pkg::CFG_KEY_COUNT: key_count = data[kdsl_pkg::COUNT_W-1:0];
        kdsl_pkg::CFG_DEBOUNCE: debounce_ms = data;
        kdsl_pkg::CFG_LONG_PRESS: long_press_ms = data;
        default: ;
      endcase
    endfunction

    // index of the only active key, -1 for none or several
    function int lone_key(logic [kdsl_pkg::KEY_W-1:0] pat);
      int found;
      found = -1;
      for (int i = 0; i < kdsl_pkg::KEY_W; i++) begin
        if (pat[i]) begin
          if (found >= 0) return -1;
          found = i;
        end
      end
      return found;
    endfunction

    // one slot stays free, so a code arriving on a full queue is lost
    function void enqueue_code(int code);
      int unsigned nxt;
      nxt = (wr_ptr + 1) % QDEPTH;
      if (nxt == rd_ptr) return;
      slots[wr_ptr] = kdsl_pkg::CODE_W'(code);
      wr_ptr = nxt;
    endfunction

    function void note_request(kdsl_pkg::in_item_t req);
      int unsigned live;
      logic [kdsl_pkg::KEY_W-1:0] keys;
      logic [kdsl_pkg::TIME_W-1:0] gap;
      kdsl_pkg::out_item_t res;
      int k;
      live = (key_count > kdsl_pkg::MAX_KEYS) ? kdsl_pkg::MAX_KEYS : key_count;
      keys = req.key_bits & kdsl_pkg::KEY_W'((1 << live) - 1);
      gap = req.now_ms - mark;
      if (req.action == kdsl_pkg::ACT_READ) begin
        res = '0;
        if (rd_ptr != wr_ptr) begin
          res.code_valid = 1'b1;
          res.key_code = slots[rd_ptr];
          rd_ptr = (rd_ptr + 1) % QDEPTH;
        end
        codes_due.push_back(res);
        return;
      end
      case (mode)
        kdsl_pkg::MODE_RELEASED: begin
          if (keys != '0) begin
            held = keys;
            mark = req.now_ms;
            mode = kdsl_pkg::MODE_DEBOUNCE;
          end
        end
        kdsl_pkg::MODE_DEBOUNCE: begin
          if (gap > debounce_ms) begin
            if (keys == held) begin
              mark = req.now_ms;
              mode = kdsl_pkg::MODE_PRESSED;
            end else begin
              mode = kdsl_pkg::MODE_IGNORE;
            end
          end else if (keys != held) begin
            mode = kdsl_pkg::MODE_IGNORE;
          end
        end
        kdsl_pkg::MODE_PRESSED: begin
          if (keys != '0) begin
            if (keys != held) begin
              mode = kdsl_pkg::MODE_IGNORE;
            end else if (gap > long_press_ms) begin
              k = lone_key(held);
              if (k >= 0) enqueue_code(k + int'(live));
              mode = kdsl_pkg::MODE_IGNORE;
            end
          end else begin
            k = lone_key(held);
            if (k >= 0) enqueue_code(k);
            mode = kdsl_pkg::MODE_RELEASED;
          end
        end
        default: begin
          if (keys == '0) mode = kdsl_pkg::MODE_RELEASED;
        end
      endcase
    endfunction

    function void check_result(kdsl_pkg::out_item_t got);
      kdsl_pkg::out_item_t want;
      if (codes_due.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected read result: code_valid=%0d key_code=%0d",
                   got.code_valid, got.key_code);
        end
        return;
      end
      want = codes_due.pop_front();
      if (got.code_valid !== want.code_valid || got.key_code !== want.key_code) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display({"read result mismatch: expected code_valid=%0d key_code=%0d,",
                    " got code_valid=%0d key_code=%0d"},
                   want.code_valid, want.key_code, got.code_valid, got.key_code);
        end
      end
    endfunction

    function int unsigned pending();
      return codes_due.size();
    endfunction

    function void flag_leftovers();
      if (codes_due.size() != 0) begin
        failures += codes_due.size();
        $display("%0d read results never arrived", codes_due.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  kdsl_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kdsl_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [kdsl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [kdsl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  press_code_tracker sb = new();

  int unsigned cycles = 0;
  int unsigned sent_count = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  // what the stimulus side believes the settings are
  int unsigned live_keys = 3;
  logic [kdsl_pkg::KEY_W-1:0] live_mask = 8'h07;
  logic [kdsl_pkg::LIMIT_W-1:0] gen_deb = kdsl_pkg::DEBOUNCE_RST;
  logic [kdsl_pkg::LIMIT_W-1:0] gen_long = kdsl_pkg::LONG_PRESS_RST;
  logic [kdsl_pkg::TIME_W-1:0] clock_ms = 32'hFFFF_FFE0;

  key_debounce_short_long_fifo_top #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(input kdsl_pkg::action_t act,
                      input logic [kdsl_pkg::KEY_W-1:0] keys,
                      input logic [kdsl_pkg::TIME_W-1:0] stamp);
    kdsl_pkg::in_item_t req;
    req.action = act;
    req.key_bits = keys;
    req.now_ms = stamp;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    sent_count++;
  endtask

  task automatic read_code();
    send(kdsl_pkg::ACT_READ, kdsl_pkg::KEY_W'($urandom), kdsl_pkg::TIME_W'($urandom));
  endtask

  // drop valid and let every due result and any sample in flight clear
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [kdsl_pkg::CFG_DATA_W-1:0] kc_word,
                            input logic [kdsl_pkg::LIMIT_W-1:0] deb,
                            input logic [kdsl_pkg::LIMIT_W-1:0] lng);
    logic [kdsl_pkg::CFG_IDX_W-1:0] regs [3];
    logic [kdsl_pkg::CFG_DATA_W-1:0] words [3];
    regs = '{kdsl_pkg::CFG_KEY_COUNT, kdsl_pkg::CFG_DEBOUNCE, kdsl_pkg::CFG_LONG_PRESS};
    words = '{kc_word, deb, lng};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= words[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(regs[i], words[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    live_keys = (kc_word[kdsl_pkg::COUNT_W-1:0] > kdsl_pkg::MAX_KEYS)
                ? kdsl_pkg::MAX_KEYS : kc_word[kdsl_pkg::COUNT_W-1:0];
    live_mask = kdsl_pkg::KEY_W'((1 << live_keys) - 1);
    gen_deb = deb;
    gen_long = lng;
  endtask

  // release, press, debounce, hold, release; garble flips one live key mid-way
  task automatic key_press(input logic [kdsl_pkg::KEY_W-1:0] pat, input bit go_long,
                           input bit garble);
    logic [kdsl_pkg::TIME_W-1:0] mark;
    logic [kdsl_pkg::KEY_W-1:0] junk;
    logic [kdsl_pkg::KEY_W-1:0] bent;
    bit early;
    junk = kdsl_pkg::KEY_W'($urandom) & ~live_mask;
    bent = pat;
    if (live_keys > 0) begin
      bent = pat ^ kdsl_pkg::KEY_W'(1 << $urandom_range(0, live_keys - 1));
    end
    early = garble && ($urandom_range(1) == 0);
    clock_ms = clock_ms + 1 + $urandom_range(0, 40);
    send(kdsl_pkg::ACT_SAMPLE, junk, clock_ms);
    clock_ms = clock_ms + 1 + $urandom_range(0, 20);
    mark = clock_ms;
    send(kdsl_pkg::ACT_SAMPLE, pat | junk, clock_ms);
    if (early) begin
      clock_ms = mark + $urandom_range(0, gen_deb);
      send(kdsl_pkg::ACT_SAMPLE, bent | junk, clock_ms);
      clock_ms = clock_ms + $urandom_range(0, 5);
      send(kdsl_pkg::ACT_SAMPLE, junk, clock_ms);
      return;
    end
    if ($urandom_range(2) == 0) begin
      clock_ms = mark + $urandom_range(0, gen_deb);
      send(kdsl_pkg::ACT_SAMPLE, pat | junk, clock_ms);
    end
    // right at the limit counts as still bouncing
    if ($urandom_range(2) == 0) begin
      clock_ms = mark + gen_deb;
      send(kdsl_pkg::ACT_SAMPLE, pat | junk, clock_ms);
    end
    clock_ms = mark + gen_deb + 1 + $urandom_range(0, 2);
    mark = clock_ms;
    send(kdsl_pkg::ACT_SAMPLE, pat | junk, clock_ms);
    if (garble) begin
      clock_ms = mark + $urandom_range(0, gen_long);
      send(kdsl_pkg::ACT_SAMPLE, bent | junk, clock_ms);
    end else if (go_long) begin
      if ($urandom_range(1) == 0) begin
        clock_ms = mark + gen_long;
        send(kdsl_pkg::ACT_SAMPLE, pat | junk, clock_ms);
      end
      clock_ms = mark + gen_long + 1 + $urandom_range(0, 3);
      send(kdsl_pkg::ACT_SAMPLE, pat | junk, clock_ms);
    end else if ($urandom_range(1) == 0) begin
      clock_ms = mark + $urandom_range(0, gen_long);
      send(kdsl_pkg::ACT_SAMPLE, pat | junk, clock_ms);
    end
    clock_ms = clock_ms + $urandom_range(0, 5);
    send(kdsl_pkg::ACT_SAMPLE, junk, clock_ms);
  endtask

  task automatic run_random(input int unsigned budget, input int unsigned read_pct);
    int unsigned stop;
    int unsigned roll;
    int unsigned a;
    int unsigned b;
    logic [kdsl_pkg::KEY_W-1:0] pat;
    stop = sent_count + budget;
    while (sent_count < stop) begin
      roll = $urandom_range(99);
      pat = '0;
      if (live_keys > 0) begin
        a = $urandom_range(0, live_keys - 1);
        pat = kdsl_pkg::KEY_W'(1 << a);
      end
      if (roll < 70) begin
        key_press(pat, 1'($urandom_range(1)), 1'b0);
      end else if (roll < 80) begin
        if (live_keys >= 2) begin
          b = (a + 1 + $urandom_range(0, live_keys - 2)) % live_keys;
          pat = pat | kdsl_pkg::KEY_W'(1 << b) | (kdsl_pkg::KEY_W'($urandom) & live_mask);
        end
        key_press(pat, 1'($urandom_range(1)), 1'b0);
      end else if (roll < 90) begin
        key_press(pat, 1'($urandom_range(1)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          clock_ms = kdsl_pkg::TIME_W'($urandom);
          send(kdsl_pkg::ACT_SAMPLE, kdsl_pkg::KEY_W'($urandom), clock_ms);
        end
      end
      if ($urandom_range(99) < read_pct) begin
        repeat ($urandom_range(1, 3)) read_code();
      end
    end
  endtask

  initial begin
    logic [kdsl_pkg::TIME_W-1:0] t0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, timestamps wrap through zero
    t0 = clock_ms;
    read_code();
    send(kdsl_pkg::ACT_SAMPLE, 8'h00, t0);
    send(kdsl_pkg::ACT_SAMPLE, 8'h01, t0 + 1);
    send(kdsl_pkg::ACT_SAMPLE, 8'h01, t0 + 61);
    send(kdsl_pkg::ACT_SAMPLE, 8'h01, t0 + 62);
    send(kdsl_pkg::ACT_SAMPLE, 8'h00, t0 + 70);
    send(kdsl_pkg::ACT_SAMPLE, 8'h04, t0 + 100);
    send(kdsl_pkg::ACT_SAMPLE, 8'h04, t0 + 161);
    send(kdsl_pkg::ACT_SAMPLE, 8'h04, t0 + 801);
    send(kdsl_pkg::ACT_SAMPLE, 8'h04, t0 + 802);
    send(kdsl_pkg::ACT_SAMPLE, 8'h00, t0 + 810);
    // two keys together never give a code
    send(kdsl_pkg::ACT_SAMPLE, 8'h03, t0 + 820);
    send(kdsl_pkg::ACT_SAMPLE, 8'h03, t0 + 881);
    send(kdsl_pkg::ACT_SAMPLE, 8'h03, t0 + 1600);
    send(kdsl_pkg::ACT_SAMPLE, 8'h00, t0 + 1610);
    // bits above the key count are masked off
    send(kdsl_pkg::ACT_SAMPLE, 8'hFA, t0 + 1620);
    send(kdsl_pkg::ACT_SAMPLE, 8'hFA, t0 + 1681);
    send(kdsl_pkg::ACT_SAMPLE, 8'hF8, t0 + 1690);
    repeat (4) read_code();
    clock_ms = t0 + 1700;

    run_random(120, 30);

    settle();
    set_config(16'd8, 16'd0, 16'd0);
    in_idle_pct = 49;
    run_random(150, 30);

    settle();
    set_config(16'd1, 16'hFFFF, 16'hFFFF);
    in_idle_pct = 0;
    out_stall_pct = 49;
    run_random(100, 30);

    // upper data bits ignored, count saturates; rare reads let the queue fill
    settle();
    set_config(16'hABCF, 16'd7, 16'd25);
    in_idle_pct = 27;
    out_stall_pct = 27;
    run_random(150, 8);

    settle();
    set_config(16'd0, 16'd3, 16'd9);
    in_idle_pct = 0;
    out_stall_pct = 0;
    run_random(60, 30);

    settle();
    set_config(16'd5, 16'd20, 16'd120);
    in_idle_pct = 49;
    run_random(130, 30);

    settle();
    set_config(16'd8, 16'd1, 16'd4);
    in_idle_pct = 0;
    out_stall_pct = 49;
    run_random(120, 5);

    settle();
    set_config(16'd2, 16'hFFFF, 16'd0);
    in_idle_pct = 27;
    out_stall_pct = 27;
    run_random(100, 30);
    repeat (QDEPTH) read_code();

    in_valid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 5000 && sb.pending() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.flag_leftovers();
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
